### design/crc32w_pkg.sv
// Shared types, constants and constant GF(2) tables for the reflected CRC-32 word engine.
// Used by the lane, merge, fold and top-level modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crc32w_pkg;

	localparam int unsigned MAX_BYTES      = 8;
	localparam int unsigned WORD_BYTES_DEF = 8;
	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;

	// Z^m applied to each single bit of a byte, for m = 0 .. MAX_BYTES.
	typedef logic [MAX_BYTES:0][7:0][31:0]  byte_cols_t;
	// Z^m applied to each single bit of a CRC word, for m = 0 .. MAX_BYTES.
	typedef logic [MAX_BYTES:0][31:0][31:0] word_cols_t;

	// Control fields that travel with a beat through the pipeline.
	typedef struct packed {
		logic [3:0]  nbytes;
		logic        first;
		logic [31:0] seed;
		logic        last;
	} ctl_t;

	// One byte's worth of zero-input steps of the reflected LFSR (the map Z).
	function automatic logic [31:0] zstep(input logic [31:0] v);
		logic [31:0] r;
		r = v;
		for (int b = 0; b < 8; b++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Evaluated at elaboration only; gives the columns of the linear maps.
	function automatic byte_cols_t byte_cols();
		byte_cols_t  t;
		logic [31:0] v;
		for (int i = 0; i < 8; i++) begin
			v = 32'(1) << i;
			for (int m = 0; m <= MAX_BYTES; m++) begin
				t[m][i] = v;
				v = zstep(v);
			end
		end
		return t;
	endfunction

	function automatic word_cols_t word_cols();
		word_cols_t  t;
		logic [31:0] v;
		for (int i = 0; i < 32; i++) begin
			v = 32'(1) << i;
			for (int m = 0; m <= MAX_BYTES; m++) begin
				t[m][i] = v;
				v = zstep(v);
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

### design/crc32w_lane.sv
// One byte lane: the byte's contribution to the word's CRC, advanced to the word end.
// Depends on crc32w_pkg for the constant byte column table.
`timescale 1ns / 1ps
`default_nettype none

module crc32w_lane #(
	parameter int unsigned LANE = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [3:0]  nbytes,
	input  wire logic [7:0]  data_byte,
	output logic      [31:0] contrib_s1
);
	import crc32w_pkg::*;

	localparam byte_cols_t BC = byte_cols();

	logic [3:0]  steps;
	logic [31:0] contrib;

	// Byte k of an n-byte word passes through n-k byte steps before the word ends.
	assign steps = nbytes - 4'(LANE);

	always_comb begin
		contrib = '0;
		if (nbytes > 4'(LANE)) begin
			for (int i = 0; i < 8; i++) begin
				if (data_byte[i]) begin
					contrib = contrib ^ BC[steps][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contrib_s1 <= contrib;
		end
	end

endmodule

`default_nettype wire

### design/crc32w_merge.sv
// Merging stage: XOR of all lane contributions into the word's data term.
// Depends on the lane outputs; no package items beyond the import convention.
`timescale 1ns / 1ps
`default_nettype none

module crc32w_merge #(
	parameter int unsigned WORD_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [WORD_BYTES-1:0][31:0]  contrib_s1,
	output logic      [31:0]                  data_s2
);
	import crc32w_pkg::*;

	logic [31:0] sum;

	always_comb begin
		sum = '0;
		for (int k = 0; k < WORD_BYTES; k++) begin
			sum = sum ^ contrib_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= sum;
		end
	end

endmodule

`default_nettype wire

### design/crc32w_fold.sv
// State update: advances the running CRC by the word length and adds the data term.
// Holds the running CRC and the output register. Depends on crc32w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crc32w_fold (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire crc32w_pkg::ctl_t  ctl_s2,
	input  wire logic [31:0]       data_s2,
	input  wire logic              out_stall,
	output logic                   out_free,
	output logic                   out_valid,
	output logic [31:0]            crc_value
);
	import crc32w_pkg::*;

	localparam word_cols_t WC = word_cols();

	logic [31:0] running_crc_q;
	logic [31:0] base;
	logic [31:0] nxt;
	logic        valid_q;
	logic [31:0] crc_q;

	assign base = ctl_s2.first ? ctl_s2.seed : running_crc_q;

	always_comb begin
		nxt = data_s2;
		for (int i = 0; i < 32; i++) begin
			if (base[i]) begin
				nxt = nxt ^ WC[ctl_s2.nbytes][i];
			end
		end
	end

	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign crc_value = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			valid_q       <= 1'b0;
		end else begin
			if (adv) begin
				running_crc_q <= nxt;
			end
			if (adv && ctl_s2.last) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.last) begin
			crc_q <= nxt;
		end
	end

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s2.last |=> valid_q)
		else $error("last beat did not produce a result");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s2.last |=> crc_q == running_crc_q)
		else $error("result differs from running CRC");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(running_crc_q))
		else $error("running CRC changed without a beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s2.last |-> out_free)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### design/crc32_reflected_word_engine.sv
// Top level of the reflected CRC-32 word engine: byte lanes, merge stage and state fold.
// Depends on crc32w_pkg, crc32w_lane, crc32w_merge and crc32w_fold.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid / in_stall   | data_word, byte_count, first, seed, last
//   output   | out_valid / out_stall | crc_value
//
// One beat per cycle is accepted while in_stall is low; out_valid rises once the last
// beat of a message has passed the lane and merge registers into the output register.
// Lanes and merge carry no state across beats, so only the fold loop on the running CRC
// sets the rate. Reset (arst_n low) clears the running CRC to zero and empties the
// pipeline. A stalled result holds in the output register while the stages in front
// keep filling; the input stalls only when a last beat waits on a full output.
`timescale 1ns / 1ps
`default_nettype none

module crc32_reflected_word_engine #(
	parameter int unsigned WORD_BYTES = crc32w_pkg::WORD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        first,
	input  wire logic [31:0] seed,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      crc_value
);
	import crc32w_pkg::*;

	logic                         accept;
	logic [3:0]                   nbytes;
	logic                         valid_s1;
	logic                         valid_s2;
	ctl_t                         ctl_s1;
	ctl_t                         ctl_s2;
	logic [WORD_BYTES-1:0][31:0]  contrib_s1;
	logic [31:0]                  data_s2;
	logic                         out_free;
	logic                         drain;
	logic                         ready_s2;
	logic                         ready_s1;
	logic                         adv;

	// A count above the lane count is clipped to the lane count.
	assign nbytes = (byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : byte_count;

	// Only a last beat needs the output register; others drain straight into the state.
	assign drain    = !ctl_s2.last || out_free;
	assign ready_s2 = !valid_s2 || drain;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv      = valid_s2 && drain;
	assign in_stall = !ready_s1;
	assign accept   = in_valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= '{nbytes: nbytes, first: first, seed: seed, last: last};
		end
		if (valid_s1 && ready_s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	for (genvar k = 0; k < WORD_BYTES; k++) begin : g_lane
		crc32w_lane #(
			.LANE(k)
		) u_lane (
			.clk       (clk),
			.en        (accept),
			.nbytes    (nbytes),
			.data_byte (data_word[8*k +: 8]),
			.contrib_s1(contrib_s1[k])
		);
	end

	crc32w_merge #(
		.WORD_BYTES(WORD_BYTES)
	) u_merge (
		.clk       (clk),
		.en        (valid_s1 && ready_s2),
		.contrib_s1(contrib_s1),
		.data_s2   (data_s2)
	);

	crc32w_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s2   (ctl_s2),
		.data_s2  (data_s2),
		.out_stall(out_stall),
		.out_free (out_free),
		.out_valid(out_valid),
		.crc_value(crc_value)
	);

endmodule

`default_nettype wire

### verif/crc32_reflected_word_engine_test.sv
// Self-checking testbench for crc32_reflected_word_engine: a queue-fed driver, a monitor
// and a bit-serial CRC predictor. Depends on crc32w_pkg and the engine RTL only.
`timescale 1ns / 1ps

module crc32_reflected_word_engine_test;

	import crc32w_pkg::*;

	localparam int unsigned NUM_BEATS   = 1550;
	localparam int unsigned IDLE_LIMIT  = 3000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam logic [31:0] POLY        = 32'hEDB88320;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
		logic [31:0] seed;
		logic        last;
		int unsigned gap;
		bit          drain;
	} beat_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [63:0] data_word  = '0;
	logic [3:0]  byte_count = '0;
	logic        first      = 1'b0;
	logic [31:0] seed       = '0;
	logic        last       = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] crc_value;

	beat_t       beat_plan[$];
	beat_t       beat_cur;
	bit          beat_loaded = 1'b0;
	int unsigned gap_left = 0;
	int unsigned gap_max = 0;
	bit          drain_next = 1'b0;
	int unsigned beats_total = 0;
	int unsigned beats_accepted = 0;

	logic [31:0] crc_running = '0;
	logic [31:0] expected_crcs[$];
	int unsigned crc_errors = 0;
	int unsigned crcs_seen = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_hold = 0;
	int unsigned idle_cycles = 0;

	crc32_reflected_word_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.first      (first),
		.seed       (seed),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value)
	);

	always #4 clk = ~clk;

	// Folds the counted low bytes into the CRC, one bit at a time, LSB first.
	function automatic logic [31:0] crc_fold_word(logic [31:0] crc_in, logic [63:0] word,
			logic [3:0] count);
		int unsigned n;
		logic [31:0] c;
		n = (count > WORD_BYTES_DEF) ? WORD_BYTES_DEF : count;
		c = crc_in;
		for (int k = 0; k < n; k++) begin
			c = c ^ {24'h0, word[8*k +: 8]};
			for (int b = 0; b < 8; b++) begin
				c = c[0] ? ((c >> 1) ^ POLY) : (c >> 1);
			end
		end
		return c;
	endfunction

	task automatic predict_crc_beat(beat_t bt);
		crc_running = crc_fold_word(bt.first ? bt.seed : crc_running, bt.data, bt.count);
		if (bt.last) begin
			expected_crcs.push_back(crc_running);
		end
	endtask

	task automatic add_beat(logic [63:0] d, logic [3:0] cnt, logic f, logic [31:0] s,
			logic l);
		beat_t bt;
		bt.data  = d;
		bt.count = cnt;
		bt.first = f;
		bt.seed  = s;
		bt.last  = l;
		bt.gap   = $urandom_range(gap_max, 0);
		bt.drain = drain_next;
		drain_next = 1'b0;
		beat_plan.push_back(bt);
	endtask

	function automatic logic [31:0] pick_seed();
		int unsigned sel;
		sel = $urandom_range(7, 0);
		if (sel == 0) begin
			return 32'h0;
		end else if (sel == 1) begin
			return 32'hFFFFFFFF;
		end
		return $urandom;
	endfunction

	function automatic logic [63:0] pick_data();
		int unsigned sel;
		sel = $urandom_range(15, 0);
		if (sel == 0) begin
			return 64'h0;
		end else if (sel == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	// Driver: a beat stays on the bus, unchanged, until the engine takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_crc_beat(beat_cur);
				beats_accepted++;
				beat_loaded = 1'b0;
			end
			if (!beat_loaded && beat_plan.size() != 0) begin
				beat_cur = beat_plan.pop_front();
				beat_loaded = 1'b1;
				gap_left = beat_cur.gap;
			end
			if (!(in_valid && in_stall)) begin
				if (beat_loaded && gap_left == 0
						&& !(beat_cur.drain && expected_crcs.size() != 0)) begin
					in_valid   <= 1'b1;
					data_word  <= beat_cur.data;
					byte_count <= beat_cur.count;
					first      <= beat_cur.first;
					seed       <= beat_cur.seed;
					last       <= beat_cur.last;
				end else begin
					in_valid <= 1'b0;
					if (beat_loaded && gap_left != 0) begin
						gap_left--;
					end
				end
			end
		end
	end

	// Monitor: checks each result and draws the stall that follows it.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_crcs.size() == 0) begin
					$display("%0t: unexpected crc_value %08h, expected none", $time, crc_value);
					crc_errors++;
				end else begin
					want = expected_crcs.pop_front();
					if (crc_value !== want) begin
						$display("%0t: crc_value mismatch, expected %08h, actual %08h",
							$time, want, crc_value);
						crc_errors++;
					end
				end
				crcs_seen++;
				if (crcs_seen == 40 || crcs_seen == 250) begin
					rx_hold = HOLD_CYCLES;
				end else if ((crcs_seen / 50) % 3 == 0) begin
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(12, 0);
				end
			end
			if (rx_hold != 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned nwords;
		logic [3:0]  cnt;
		bit          drain_done;
		drain_done = 1'b0;

		// Directed part. The engine starts from zero when no first comes after reset.
		gap_max = 3;
		add_beat(64'h0123456789ABCDEF, 4'd8, 1'b0, 32'hDEADBEEF, 1'b1);
		add_beat(pick_data(), 4'd0, 1'b1, 32'hFFFFFFFF, 1'b1);
		add_beat(64'h0, 4'd0, 1'b1, 32'h0, 1'b1);
		add_beat(64'h00000000000000A5, 4'd1, 1'b1, 32'hFFFFFFFF, 1'b1);
		add_beat(64'hFFFFFFFFFF332211, 4'd3, 1'b1, 32'h12345678, 1'b1);
		add_beat(64'h3837363534333231, 4'd8, 1'b1, 32'hFFFFFFFF, 1'b0);
		add_beat(64'hFFFFFFFFFFFFFF39, 4'd1, 1'b0, 32'hA5A5A5A5, 1'b1);
		add_beat('1, 4'd15, 1'b1, 32'hFFFFFFFF, 1'b1);
		add_beat('1, 4'd9, 1'b1, 32'h0, 1'b1);
		add_beat(64'h0, 4'd8, 1'b1, 32'hFFFFFFFF, 1'b1);
		add_beat('1, 4'd8, 1'b1, 32'h0, 1'b1);
		// Short word at the start of a message, then more words that ignore their seed.
		add_beat(pick_data(), 4'd3, 1'b1, 32'h89ABCDEF, 1'b0);
		add_beat(pick_data(), 4'd8, 1'b0, 32'hFFFFFFFF, 1'b0);
		add_beat(pick_data(), 4'd5, 1'b0, 32'h0, 1'b1);
		// Continues from the emitted value without a new first.
		add_beat(pick_data(), 4'd4, 1'b0, 32'h55555555, 1'b1);
		add_beat(pick_data(), 4'd2, 1'b1, 32'hAAAAAAAA, 1'b1);
		add_beat(pick_data(), 4'd0, 1'b0, 32'h0, 1'b1);
		drain_next = 1'b1;
		add_beat(pick_data(), 4'd7, 1'b1, pick_seed(), 1'b1);
		add_beat(pick_data(), 4'd6, 1'b1, pick_seed(), 1'b0);
		add_beat(pick_data(), 4'd12, 1'b0, pick_seed(), 1'b1);

		// Random part: mostly well-formed messages, some broken ones and loose beats.
		while (beat_plan.size() < NUM_BEATS) begin
			gap_max = ((beat_plan.size() / 120) % 2 == 0) ? 0 : 12;
			kind = $urandom_range(11, 0);
			if (!drain_done && beat_plan.size() >= 800) begin
				drain_next = 1'b1;
				drain_done = 1'b1;
			end
			if (kind == 0) begin
				add_beat({$urandom, $urandom}, 4'($urandom_range(15, 0)), 1'($urandom),
					$urandom, 1'($urandom));
			end else begin
				nwords = ($urandom_range(3, 0) == 0) ? 1 : $urandom_range(6, 1);
				for (int w = 0; w < nwords; w++) begin
					if (w == nwords - 1) begin
						cnt = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 9))
							: 4'($urandom_range(8, 0));
					end else if (kind == 2) begin
						cnt = 4'($urandom_range(15, 0));
					end else begin
						cnt = 4'd8;
					end
					add_beat(pick_data(), cnt, (w == 0) && (kind != 1), pick_seed(),
						(w == nwords - 1) && (kind != 3));
				end
			end
		end
		beats_total = beat_plan.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while ((beats_accepted != beats_total || expected_crcs.size() != 0)
				&& idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d beats taken, %0d results pending", $time,
				beats_accepted, beats_total, expected_crcs.size());
			$display("== FAIL ==");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (expected_crcs.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time,
					expected_crcs.size());
				crc_errors++;
			end
			if (crc_errors == 0) begin
				$display("== PASS ==");
			end else begin
				$display("== FAIL ==");
			end
		end
		$finish;
	end

endmodule

### crc32_reflected_word_engine.f
design/crc32w_pkg.sv
design/crc32w_lane.sv
design/crc32w_merge.sv
design/crc32w_fold.sv
design/crc32_reflected_word_engine.sv
verif/crc32_reflected_word_engine_test.sv
